// ----- rtl/core/mcr_pkg.sv -----
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and codes for the midpoint circle rasteriser.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

  // request codes on the cmd field
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  // last of the eight mirrored points of a run
  localparam logic [2:0] OCT_LAST = 3'd7;

  // run queue status seen by both sides
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/mcr_front.sv -----
// ----------------------------------------------------------------------------
// mcr_front
// Takes requests, keeps the midpoint stepping state and queues one run
// descriptor per request that emits points.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_front #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          cmd,
  input  wire logic signed [COORD_BITS-1:0]  center_x,
  input  wire logic signed [COORD_BITS-1:0]  center_y,
  input  wire logic        [RADIUS_BITS-1:0] radius,
  input  wire logic        [31:0]            pen_color,
  input  wire mcr_pkg::q_status_t            q_status,
  output logic                               push_valid,
  output logic signed [COORD_BITS-1:0]       run_col,
  output logic signed [COORD_BITS-1:0]       run_row,
  output logic        [RADIUS_BITS:0]        run_x,
  output logic signed [RADIUS_BITS+1:0]      run_y,
  output logic        [31:0]                 run_color,
  output logic                               run_ends
);
  import mcr_pkg::*;

  localparam int XW = RADIUS_BITS + 1;
  localparam int SW = RADIUS_BITS + 2;
  localparam int DW = RADIUS_BITS + 6;

  logic signed [COORD_BITS-1:0] col;
  logic signed [COORD_BITS-1:0] row;
  logic        [XW-1:0]         x;
  logic signed [SW-1:0]         y;
  logic signed [DW-1:0]         d;
  logic        [31:0]           color;
  logic                         busy;

  logic [XW-1:0]         x_next;
  logic signed [SW-1:0]  y_next;
  logic signed [DW-1:0]  d_next;
  logic                  busy_next;

  logic [XW-1:0]         x_inc;
  logic signed [SW-1:0]  x_inc_s;
  logic signed [SW-1:0]  y_step;
  logic signed [SW-1:0]  diff;
  logic                  d_pos;
  logic                  accept;
  logic                  is_start;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign is_start = (cmd == CMD_START);

  assign x_inc   = x + XW'(1);
  assign x_inc_s = $signed({1'b0, x_inc});
  assign d_pos   = !d[DW-1] && (d != '0);
  assign y_step  = d_pos ? (y - SW'(1)) : y;
  assign diff    = x_inc_s - y_step;

  always_comb begin
    if (is_start) begin
      x_next    = '0;
      y_next    = $signed(SW'(radius));
      d_next    = DW'(3) - (DW'(radius) << 1);
      busy_next = 1'b1;
    end else begin
      x_next = x_inc;
      y_next = y_step;
      if (d_pos) begin
        d_next = d + (DW'(diff) <<< 2) + DW'(10);
      end else begin
        d_next = d + (DW'(x_inc_s) <<< 2) + DW'(6);
      end
      busy_next = (y_step >= x_inc_s);
    end
  end

  // advance with no circle running is absorbed silently
  assign push_valid = accept && (is_start || busy);
  assign run_col    = is_start ? center_x : col;
  assign run_row    = is_start ? center_y : row;
  assign run_color  = is_start ? pen_color : color;
  assign run_x      = x_next;
  assign run_y      = y_next;
  assign run_ends   = !busy_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      color <= '0;
      x     <= '0;
      y     <= '0;
      d     <= '0;
    end else if (push_valid) begin
      col   <= run_col;
      row   <= run_row;
      color <= run_color;
      x     <= x_next;
      y     <= y_next;
      d     <= d_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (push_valid) begin
      busy <= busy_next;
    end
  end

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    accept && is_start |=> busy)
    else $error("start request did not leave a circle active");
  a_idle_no_push: assert property (@(posedge clk) disable iff (rst)
    !busy && !is_start |-> !push_valid)
    else $error("advance while idle queued a run");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/mcr_fifo.sv -----
// ----------------------------------------------------------------------------
// mcr_fifo
// Two-entry run queue between the stepping front and the point emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      head,
  output mcr_pkg::q_status_t    q_status
);
  import mcr_pkg::*;

  localparam int DEPTH = 2;

  logic [WIDTH-1:0] mem [DEPTH];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign q_status.empty = (count == 2'd0);
  assign q_status.full  = (count == 2'(DEPTH));
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign head           = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH))
    else $error("run queue count beyond depth");
  a_push_lost: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("run pushed into full queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/mcr_back.sv -----
// ----------------------------------------------------------------------------
// mcr_back
// Point emitter: walks 8 mirrored points per queued run, one a cycle if ready.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_back #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mcr_pkg::q_status_t            q_status,
  input  wire logic signed [COORD_BITS-1:0]  run_col,
  input  wire logic signed [COORD_BITS-1:0]  run_row,
  input  wire logic        [RADIUS_BITS:0]   run_x,
  input  wire logic signed [RADIUS_BITS+1:0] run_y,
  input  wire logic        [31:0]            run_color,
  input  wire logic                          run_ends,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_BITS:0]         pixel_x,
  output logic signed [COORD_BITS:0]         pixel_y,
  output logic        [31:0]                 pixel_color,
  output logic        [2:0]                  octant,
  output logic                               run_last,
  output logic                               circle_done
);
  import mcr_pkg::*;

  localparam int PW = COORD_BITS + 1;
  localparam int SW = RADIUS_BITS + 2;
  localparam int WW = (PW > SW) ? PW : SW;

  logic [2:0]           oct;
  logic                 fire;
  logic signed [SW-1:0] xs;
  logic signed [SW-1:0] a;
  logic signed [SW-1:0] b;
  logic signed [WW-1:0] col_w;
  logic signed [WW-1:0] row_w;
  logic signed [WW-1:0] a_w;
  logic signed [WW-1:0] b_w;
  logic signed [WW-1:0] px_w;
  logic signed [WW-1:0] py_w;

  assign out_valid = !q_status.empty;
  assign fire      = out_valid && out_ready;
  assign run_last  = (oct == OCT_LAST);
  assign pop       = fire && run_last;

  // upper four points swap the roles of x and y
  assign xs    = $signed({1'b0, run_x});
  assign a     = oct[2] ? run_y : xs;
  assign b     = oct[2] ? xs : run_y;
  assign col_w = WW'(run_col);
  assign row_w = WW'(run_row);
  assign a_w   = WW'(a);
  assign b_w   = WW'(b);
  assign px_w  = oct[0] ? (col_w - a_w) : (col_w + a_w);
  assign py_w  = oct[1] ? (row_w - b_w) : (row_w + b_w);

  assign pixel_x     = px_w[PW-1:0];
  assign pixel_y     = py_w[PW-1:0];
  assign pixel_color = run_color;
  assign octant      = oct;
  assign circle_done = run_last && run_ends;

  always_ff @(posedge clk) begin
    if (rst) begin
      oct <= 3'd0;
    end else if (fire) begin
      oct <= oct + 3'd1;
    end
  end

`ifndef SYNTHESIS
  a_run_held: assert property (@(posedge clk) disable iff (rst)
    oct != 3'd0 |-> !q_status.empty)
    else $error("run left the queue part-way through its points");
  a_wrap: assert property (@(posedge clk) disable iff (rst)
    pop |=> oct == 3'd0)
    else $error("point counter did not wrap at end of run");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/midpoint_circle_rasterizer.sv -----
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer
// Midpoint circle outliner with eight-way symmetry, front/back split.
// ----------------------------------------------------------------------------
// A request is taken whenever the two-entry run queue has room; a start,
// or an advance while a circle is running, queues one run, which the
// emitter sends as eight points at one point a cycle while out_ready is
// high, so such requests can be taken before the emitter is through with
// the last run. An advance with no circle running gives no points. Up to
// two runs may wait in the queue, so the front keeps stepping while the
// output stalls, until the queue is full. No clearing pass after reset.
`default_nettype none

module midpoint_circle_rasterizer #(
  parameter int COORD_BITS  = 16,
  parameter int RADIUS_BITS = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          cmd,
  input  wire logic signed [COORD_BITS-1:0]  center_x,
  input  wire logic signed [COORD_BITS-1:0]  center_y,
  input  wire logic        [RADIUS_BITS-1:0] radius,
  input  wire logic        [31:0]            pen_color,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_BITS:0]         pixel_x,
  output logic signed [COORD_BITS:0]         pixel_y,
  output logic        [31:0]                 pixel_color,
  output logic        [2:0]                  octant,
  output logic                               run_last,
  output logic                               circle_done
);
  import mcr_pkg::*;

  localparam int XW = RADIUS_BITS + 1;
  localparam int SW = RADIUS_BITS + 2;
  localparam int QW = 2 * COORD_BITS + XW + SW + 32 + 1;

  q_status_t                    q_status;
  logic                         push_valid;
  logic                         pop;
  logic signed [COORD_BITS-1:0] f_col;
  logic signed [COORD_BITS-1:0] f_row;
  logic        [XW-1:0]         f_x;
  logic signed [SW-1:0]         f_y;
  logic        [31:0]           f_color;
  logic                         f_ends;
  logic signed [COORD_BITS-1:0] b_col;
  logic signed [COORD_BITS-1:0] b_row;
  logic        [XW-1:0]         b_x;
  logic signed [SW-1:0]         b_y;
  logic        [31:0]           b_color;
  logic                         b_ends;
  logic [QW-1:0]                q_in;
  logic [QW-1:0]                q_head;

  mcr_front #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .center_x   (center_x),
    .center_y   (center_y),
    .radius     (radius),
    .pen_color  (pen_color),
    .q_status   (q_status),
    .push_valid (push_valid),
    .run_col    (f_col),
    .run_row    (f_row),
    .run_x      (f_x),
    .run_y      (f_y),
    .run_color  (f_color),
    .run_ends   (f_ends)
  );

  assign q_in = {f_col, f_row, f_x, f_y, f_color, f_ends};

  mcr_fifo #(
    .WIDTH (QW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data (q_in),
    .pop       (pop),
    .head      (q_head),
    .q_status  (q_status)
  );

  assign {b_col, b_row, b_x, b_y, b_color, b_ends} = q_head;

  mcr_back #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_status    (q_status),
    .run_col     (b_col),
    .run_row     (b_row),
    .run_x       (b_x),
    .run_y       (b_y),
    .run_color   (b_color),
    .run_ends    (b_ends),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .octant      (octant),
    .run_last    (run_last),
    .circle_done (circle_done)
  );

endmodule

`default_nettype wire
